@@ rtl/core/mqs_pkg.sv @@
package mqs_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int IDX_W      = $clog2(MAX_JOBS);
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);
    localparam int QA_W       = IDX_W + 1;

    localparam int TIME_W     = 21;
    localparam int ARR_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int KIND_W     = 3;
    localparam int JIDX_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [ARR_W-1:0]  QUANTUM_RESET = 16'd4;
    localparam logic [PRIO_W-1:0] LIMIT_RESET   = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'b1;

    localparam logic Q_RR   = 1'b0;
    localparam logic Q_FCFS = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD     = 3'd0,
        KIND_RUN      = 3'd1,
        KIND_IDLE     = 3'd2,
        KIND_ALL_DONE = 3'd3,
        KIND_LOAD_ERR = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADM_RD,
        S_ADM_CHK,
        S_DISPATCH,
        S_POP_WAIT,
        S_JOB_WAIT,
        S_EXEC,
        S_POST,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [ARR_W-1:0]  quantum;
        logic [PRIO_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [ARR_W-1:0]  arrival;
        logic [ARR_W-1:0]  burst;
        logic [PRIO_W-1:0] prio;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [JIDX_W-1:0] job_index;
        logic [ARR_W-1:0]  slice_length;
        logic              job_done;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] now;
    } res_t;

    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [ARR_W-1:0] burst;
        logic [ARR_W-1:0] remaining;
        logic             high;
    } job_t;

    function automatic logic [JIDX_W-1:0] to_jidx(input logic [IDX_W-1:0] i);
        logic [31:0] w;
        w = 32'(i);
        return w[JIDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/mqs_if.sv @@
interface mqs_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [mqs_pkg::ARR_W-1:0]      arrival;
    logic [mqs_pkg::ARR_W-1:0]      burst;
    logic [mqs_pkg::PRIO_W-1:0]     prio;

    modport source (output valid, mode, arrival, burst, prio, input ready);
    modport sink   (input valid, mode, arrival, burst, prio, output ready);
endinterface

interface mqs_out_if;
    logic                           valid;
    logic                           ready;
    logic [mqs_pkg::KIND_W-1:0]     kind;
    logic [mqs_pkg::JIDX_W-1:0]     job_index;
    logic [mqs_pkg::ARR_W-1:0]      slice_length;
    logic                           job_done;
    logic [mqs_pkg::TIME_W-1:0]     turnaround;
    logic [mqs_pkg::TIME_W-1:0]     waiting;
    logic [mqs_pkg::TIME_W-1:0]     now;

    modport source (output valid, kind, job_index, slice_length, job_done, turnaround,
                    waiting, now, input ready);
    modport sink   (input valid, kind, job_index, slice_length, job_done, turnaround,
                    waiting, now, output ready);
endinterface

@@ rtl/core/mqs_ram.sv @@
module mqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/mqs_seq.sv @@
module mqs_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  mqs_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  mqs_pkg::item_t in_data,
    output logic          in_ready,
    output logic          res_valid,
    output mqs_pkg::res_t res,
    input  logic          res_ready
);

    import mqs_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  adm_reg, adm_next;
    logic [ARR_W-1:0]  last_arr_reg, last_arr_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [IDX_W-1:0]  rr_head_reg, rr_head_next;
    logic [CNT_W-1:0]  rr_cnt_reg, rr_cnt_next;
    logic [IDX_W-1:0]  fc_head_reg, fc_head_next;
    logic [CNT_W-1:0]  fc_cnt_reg, fc_cnt_next;

    logic [ARR_W-1:0]  next_arr_reg, next_arr_next;
    logic [IDX_W-1:0]  job_reg, job_next;
    logic              from_rr_reg, from_rr_next;
    logic [ARR_W-1:0]  arr_reg, arr_next;
    logic [ARR_W-1:0]  burst_reg, burst_next;
    logic [ARR_W-1:0]  rem_reg, rem_next;
    logic              hi_reg, hi_next;
    logic [ARR_W-1:0]  slice_reg, slice_next;
    kind_t             kind_reg, kind_next;
    logic [JIDX_W-1:0] idx_reg, idx_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] ta_reg, ta_next;

    logic                    jm_we, jm_re;
    logic [IDX_W-1:0]        jm_waddr, jm_raddr;
    logic [$bits(job_t)-1:0] jm_wdata, jm_rdata;
    job_t                    jrd, jwr;

    logic             qm_we, qm_re;
    logic [QA_W-1:0]  qm_waddr, qm_raddr;
    logic [IDX_W-1:0] qm_wdata, qm_rdata;

    logic             accept;
    logic             load_err;
    logic             pending;
    logic [ARR_W-1:0] q_eff;
    logic [IDX_W-1:0] rr_tail, fc_tail;

    mqs_ram #(
        .WIDTH ($bits(job_t)),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .clk   (clk),
        .we    (jm_we),
        .waddr (jm_waddr),
        .wdata (jm_wdata),
        .re    (jm_re),
        .raddr (jm_raddr),
        .rdata (jm_rdata)
    );

    mqs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (2 * MAX_JOBS)
    ) u_queue_ram (
        .clk   (clk),
        .we    (qm_we),
        .waddr (qm_waddr),
        .wdata (qm_wdata),
        .re    (qm_re),
        .raddr (qm_raddr),
        .rdata (qm_rdata)
    );

    assign jrd      = job_t'(jm_rdata);
    assign jm_wdata = jwr;
    assign accept   = in_valid && in_ready;
    assign pending  = adm_reg < loaded_reg;
    assign load_err = (loaded_reg == CNT_W'(MAX_JOBS)) ||
                      ((loaded_reg != '0) && (in_data.arrival < last_arr_reg));
    assign q_eff    = (cfg.quantum == '0) ? ARR_W'(1) : cfg.quantum;
    assign rr_tail  = rr_head_reg + rr_cnt_reg[IDX_W-1:0];
    assign fc_tail  = fc_head_reg + fc_cnt_reg[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_data.mode ? S_ADM_RD : S_RESULT;
                end
            end
            S_ADM_RD:
            begin
                if (pending)
                begin
                    state_next = S_ADM_CHK;
                end
                else
                begin
                    state_next = phase_reg ? S_POST : S_DISPATCH;
                end
            end
            S_ADM_CHK:
            begin
                if (TIME_W'(jrd.arrival) <= time_reg)
                begin
                    state_next = S_ADM_RD;
                end
                else
                begin
                    state_next = phase_reg ? S_POST : S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (rr_cnt_reg != '0 || fc_cnt_reg != '0)
                begin
                    state_next = S_POP_WAIT;
                end
                else if (pending)
                begin
                    state_next = S_ADM_RD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_POP_WAIT: state_next = S_JOB_WAIT;
            S_JOB_WAIT: state_next = S_EXEC;
            S_EXEC:     state_next = S_ADM_RD;
            S_POST:     state_next = S_RESULT;
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        phase_next    = phase_reg;
        loaded_next   = loaded_reg;
        adm_next      = adm_reg;
        last_arr_next = last_arr_reg;
        time_next     = time_reg;
        rr_head_next  = rr_head_reg;
        rr_cnt_next   = rr_cnt_reg;
        fc_head_next  = fc_head_reg;
        fc_cnt_next   = fc_cnt_reg;
        next_arr_next = next_arr_reg;
        job_next      = job_reg;
        from_rr_next  = from_rr_reg;
        arr_next      = arr_reg;
        burst_next    = burst_reg;
        rem_next      = rem_reg;
        hi_next       = hi_reg;
        slice_next    = slice_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        done_next     = done_reg;
        ta_next       = ta_reg;

        jm_we    = 1'b0;
        jm_waddr = job_reg;
        jwr      = '{arrival: arr_reg, burst: burst_reg, remaining: rem_reg, high: hi_reg};
        jm_re    = 1'b0;
        jm_raddr = adm_reg[IDX_W-1:0];
        qm_we    = 1'b0;
        qm_waddr = {Q_RR, rr_tail};
        qm_wdata = job_reg;
        qm_re    = 1'b0;
        qm_raddr = {Q_RR, rr_head_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    slice_next = '0;
                    done_next  = 1'b0;
                    idx_next   = '0;
                    phase_next = 1'b0;
                    kind_next  = KIND_ALL_DONE;
                    if (!in_data.mode)
                    begin
                        if (load_err)
                        begin
                            kind_next = KIND_LOAD_ERR;
                        end
                        else
                        begin
                            kind_next     = KIND_LOAD;
                            idx_next      = to_jidx(loaded_reg[IDX_W-1:0]);
                            jm_we         = 1'b1;
                            jm_waddr      = loaded_reg[IDX_W-1:0];
                            jwr           = '{arrival: in_data.arrival,
                                              burst: in_data.burst,
                                              remaining: in_data.burst,
                                              high: in_data.prio < cfg.limit};
                            last_arr_next = in_data.arrival;
                            loaded_next   = loaded_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_ADM_RD:
            begin
                if (pending)
                begin
                    jm_re = 1'b1;
                end
            end
            S_ADM_CHK:
            begin
                next_arr_next = jrd.arrival;
                if (TIME_W'(jrd.arrival) <= time_reg)
                begin
                    qm_we    = 1'b1;
                    qm_wdata = adm_reg[IDX_W-1:0];
                    if (jrd.high)
                    begin
                        qm_waddr    = {Q_RR, rr_tail};
                        rr_cnt_next = rr_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        qm_waddr    = {Q_FCFS, fc_tail};
                        fc_cnt_next = fc_cnt_reg + CNT_W'(1);
                    end
                    adm_next = adm_reg + CNT_W'(1);
                end
            end
            S_DISPATCH:
            begin
                if (rr_cnt_reg != '0)
                begin
                    qm_re        = 1'b1;
                    qm_raddr     = {Q_RR, rr_head_reg};
                    rr_head_next = rr_head_reg + IDX_W'(1);
                    rr_cnt_next  = rr_cnt_reg - CNT_W'(1);
                    from_rr_next = 1'b1;
                end
                else if (fc_cnt_reg != '0)
                begin
                    qm_re        = 1'b1;
                    qm_raddr     = {Q_FCFS, fc_head_reg};
                    fc_head_next = fc_head_reg + IDX_W'(1);
                    fc_cnt_next  = fc_cnt_reg - CNT_W'(1);
                    from_rr_next = 1'b0;
                end
                else if (pending)
                begin
                    // idle up to the next arrival, then admit
                    slice_next = next_arr_reg - time_reg[ARR_W-1:0];
                    time_next  = TIME_W'(next_arr_reg);
                    kind_next  = KIND_IDLE;
                    phase_next = 1'b1;
                end
                else
                begin
                    kind_next = KIND_ALL_DONE;
                end
            end
            S_POP_WAIT:
            begin
                job_next = qm_rdata;
                jm_re    = 1'b1;
                jm_raddr = qm_rdata;
            end
            S_JOB_WAIT:
            begin
                arr_next   = jrd.arrival;
                burst_next = jrd.burst;
                rem_next   = jrd.remaining;
                hi_next    = jrd.high;
                if (from_rr_reg && (q_eff < jrd.remaining))
                begin
                    slice_next = q_eff;
                end
                else
                begin
                    slice_next = jrd.remaining;
                end
            end
            S_EXEC:
            begin
                rem_next   = rem_reg - slice_reg;
                jm_we      = 1'b1;
                jm_waddr   = job_reg;
                jwr        = '{arrival: arr_reg, burst: burst_reg,
                               remaining: rem_reg - slice_reg, high: hi_reg};
                time_next  = time_reg + TIME_W'(slice_reg);
                kind_next  = KIND_RUN;
                idx_next   = to_jidx(job_reg);
                done_next  = (rem_reg == slice_reg);
                phase_next = 1'b1;
            end
            S_POST:
            begin
                // preempted round-robin job goes behind the ones admitted meanwhile
                if (kind_reg == KIND_RUN && from_rr_reg && rem_reg != '0)
                begin
                    qm_we       = 1'b1;
                    qm_waddr    = {Q_RR, rr_tail};
                    qm_wdata    = job_reg;
                    rr_cnt_next = rr_cnt_reg + CNT_W'(1);
                end
                ta_next = time_reg - TIME_W'(arr_reg);
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready         = (state_reg == S_IDLE);
        res_valid        = (state_reg == S_RESULT);
        res.kind         = kind_reg;
        res.job_index    = idx_reg;
        res.slice_length = slice_reg;
        res.job_done     = done_reg;
        res.turnaround   = done_reg ? ta_reg : '0;
        res.waiting      = done_reg ? (ta_reg - TIME_W'(burst_reg)) : '0;
        res.now          = time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= 1'b0;
            loaded_reg  <= '0;
            adm_reg     <= '0;
            time_reg    <= '0;
            rr_head_reg <= '0;
            rr_cnt_reg  <= '0;
            fc_head_reg <= '0;
            fc_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            loaded_reg  <= loaded_next;
            adm_reg     <= adm_next;
            time_reg    <= time_next;
            rr_head_reg <= rr_head_next;
            rr_cnt_reg  <= rr_cnt_next;
            fc_head_reg <= fc_head_next;
            fc_cnt_reg  <= fc_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_arr_reg <= last_arr_next;
        next_arr_reg <= next_arr_next;
        job_reg      <= job_next;
        from_rr_reg  <= from_rr_next;
        arr_reg      <= arr_next;
        burst_reg    <= burst_next;
        rem_reg      <= rem_next;
        hi_reg       <= hi_next;
        slice_reg    <= slice_next;
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        done_reg     <= done_next;
        ta_reg       <= ta_next;
    end

endmodule

@@ rtl/core/multilevel_queue_scheduler_core.sv @@
// two-level queue scheduler: round-robin queue over first-come queue
// item channel (valid/ready): mode 0 loads a job record (arrival, burst, prio)
// into a 16-entry job table, mode 1 runs one scheduling step
// result channel (valid/ready): exactly one result transaction per item:
// load ack or load error, run slice, idle slice, or all finished
// config port: cfg_we writes quantum (index 0) or high_class_limit (index 1)
// job table and both queues live in synchronous memories with registered reads;
// every access goes through the sequencer, one read-modify-write at a time
// a load result passes the sequencer's result state and then the output register
// a step's length grows with the jobs admitted during it, as the admission walk
// reads and checks one job table entry at a time
// one item is in work at a time; the item channel is ready again as soon as
// the result sits in the output register, even while the receiver stalls
// a stalled result holds the output register; a following result waits in
// the sequencer until the register frees
// reset empties both queues, clears time and counts, quantum 4, limit 3
module multilevel_queue_scheduler_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mqs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mqs_pkg::CFG_DATA_W-1:0]   cfg_data,
    mqs_in_if.sink                           item,
    mqs_out_if.source                        result
);

    import mqs_pkg::*;

    cfg_t  cfg_reg;
    item_t in_data;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  res_valid;
    logic  res_ready;
    logic  in_ready;

    assign in_data = '{mode: item.mode, arrival: item.arrival, burst: item.burst,
                       prio: item.prio};
    assign item.ready = in_ready;

    mqs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (item.valid),
        .in_data   (in_data),
        .in_ready  (in_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quantum <= QUANTUM_RESET;
            cfg_reg.limit   <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUANTUM: cfg_reg.quantum <= cfg_data;
                CFG_LIMIT:   cfg_reg.limit   <= cfg_data[PRIO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // output register
    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = KIND_W'(out_reg.kind);
    assign result.job_index    = out_reg.job_index;
    assign result.slice_length = out_reg.slice_length;
    assign result.job_done     = out_reg.job_done;
    assign result.turnaround   = out_reg.turnaround;
    assign result.waiting      = out_reg.waiting;
    assign result.now          = out_reg.now;

endmodule
